[hw/rtl/sfp_pkg.sv]
`default_nettype none

package sfp_pkg;

	// Input item selector codes.
	localparam logic [2:0] REQ_IMU      = 3'd0;
	localparam logic [2:0] REQ_LEFT     = 3'd1;
	localparam logic [2:0] REQ_RIGHT    = 3'd2;
	localparam logic [2:0] REQ_SETTINGS = 3'd3;
	localparam logic [2:0] REQ_PACKET   = 3'd4;

	// Positions of words inside their groups.
	localparam logic [2:0] IDX_FIRST    = 3'd0;
	localparam logic [2:0] IDX_SECOND   = 3'd1;
	localparam logic [2:0] IDX_IMU_LAST = 3'd5;

	// Fall direction codes on a packet request.
	localparam logic [1:0] SIDE_FORWARD  = 2'd0;
	localparam logic [1:0] SIDE_BACKWARD = 2'd1;

	// Settings control word bits.
	localparam int unsigned CTRL_REQUEST_BIT = 8;
	localparam int unsigned CTRL_TARE_BIT    = 9;

	// Frame constants.
	localparam logic [23:0] FRAME_HEADER  = 24'h5354F7;
	localparam logic [7:0]  FRAME_TRAILER = 8'h45;
	localparam logic [7:0]  FRAME_FILL    = 8'hFF;
	localparam logic [2:0]  FRAME_LAST    = 3'd6;

	// Stand status characters.
	localparam logic [7:0] STATUS_STAND    = 8'h53;
	localparam logic [7:0] STATUS_FORWARD  = 8'h46;
	localparam logic [7:0] STATUS_BACKWARD = 8'h42;

	// Angle wrap limits in hundredths of a degree.
	localparam logic signed [16:0] HALF_TURN = 17'sd18000;
	localparam logic signed [16:0] FULL_TURN = 17'sd36000;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [31:0] data_word;
		logic [2:0]  word_index;
		logic        stop_walk;
		logic [1:0]  fall_side;
	} item_t;

	typedef struct packed {
		logic [31:0] packet_word;
		logic [2:0]  word_number;
		logic        last_word;
	} frame_word_t;

endpackage

`default_nettype wire

[hw/rtl/sensor_frame_packer_top.sv]
// Sensor words update the block state at the edge that accepts them; one word per cycle outside frame bursts.
// A packet request, when armed by fresh settings, puts frame word 0 out in the cycle after acceptance and
// then one word per cycle while the consumer takes them: seven words in all.
// During a frame burst new items wait, except in the cycle in which the last word is taken.
// Reset clears control state, angles and pressures to zero and the status to standing.
// The IMU and pressure hold words have no reset value.
`default_nettype none

module sensor_frame_packer_top (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                item_valid,
	output logic                     item_ready,
	input  wire sfp_pkg::item_t      item,
	output logic                     frame_valid,
	input  wire logic                frame_ready,
	output sfp_pkg::frame_word_t     frame
);
	import sfp_pkg::*;

	logic [31:0] imu_w0_q;
	logic [31:0] imu_w1_q;
	logic [31:0] press_w0_q;
	logic [15:0] raw_q [3];
	logic [15:0] offset_q [3];
	logic [15:0] angle_sm_q [3];
	logic [14:0] pressure_q [8];
	logic        req_en_q;
	logic        fresh_q;
	logic [7:0]  status_q;
	logic        busy_q;
	logic [2:0]  cnt_q;

	logic        item_fire;
	logic        frame_fire;
	logic        frame_done;
	logic        start;
	logic        imu_update;
	logic        press_update;
	logic        ctrl_write;
	logic [15:0] raw_d [3];
	logic [15:0] angle_d [3];
	logic [14:0] press_d [4];
	logic [7:0]  status_d;
	logic [175:0] flat;

	function automatic logic [15:0] sm_to_tc(input logic [15:0] h);
		logic [15:0] mag;
		mag = {1'b0, h[14:0]};
		return h[15] ? 16'(-mag) : mag;
	endfunction

	// Subtract the tare offset, wrap into a half turn, return sign-magnitude.
	function automatic logic [15:0] wrap_sm(input logic [15:0] raw, input logic [15:0] off);
		logic signed [16:0] d;
		logic signed [16:0] w;
		logic [15:0]        v;
		logic [15:0]        neg;
		d = 17'(signed'(raw)) - 17'(signed'(off));
		if (d < -HALF_TURN) begin
			w = d + FULL_TURN;
		end else if (d > HALF_TURN) begin
			w = d - FULL_TURN;
		end else begin
			w = d;
		end
		v = w[15:0];
		neg = 16'(-v);
		return v[15] ? {1'b1, neg[14:0]} : v;
	endfunction

	function automatic logic [14:0] press_half(input logic [15:0] h);
		return h[15] ? 15'd0 : h[14:0];
	endfunction

	assign frame_done = frame_fire && (cnt_q == FRAME_LAST);
	assign item_ready = !busy_q || (frame_ready && (cnt_q == FRAME_LAST));
	assign item_fire  = item_valid && item_ready;
	assign frame_fire = frame_valid && frame_ready;

	assign imu_update   = item_fire && item.req_type == REQ_IMU &&
		item.word_index == IDX_IMU_LAST && imu_w0_q != imu_w1_q;
	assign press_update = item_fire && (item.req_type == REQ_LEFT ||
		item.req_type == REQ_RIGHT) && item.word_index == IDX_SECOND;
	assign ctrl_write   = item_fire && item.req_type == REQ_SETTINGS &&
		item.word_index == IDX_SECOND;
	assign start        = item_fire && item.req_type == REQ_PACKET && req_en_q && fresh_q;

	always_comb begin
		raw_d[0] = sm_to_tc(imu_w0_q[31:16]);
		raw_d[1] = sm_to_tc(imu_w0_q[15:0]);
		raw_d[2] = sm_to_tc(imu_w1_q[31:16]);
		for (int i = 0; i < 3; i++) begin
			angle_d[i] = wrap_sm(raw_d[i], offset_q[i]);
		end
		press_d[0] = press_half(press_w0_q[31:16]);
		press_d[1] = press_half(press_w0_q[15:0]);
		press_d[2] = press_half(item.data_word[31:16]);
		press_d[3] = press_half(item.data_word[15:0]);
	end

	always_comb begin
		status_d = STATUS_STAND;
		if (item.stop_walk) begin
			case (item.fall_side)
				SIDE_FORWARD:  status_d = STATUS_FORWARD;
				SIDE_BACKWARD: status_d = STATUS_BACKWARD;
				default:       status_d = status_q;
			endcase
		end
	end

	// The user must write hold words before they are read; the block itself does not enforce this.
	always_ff @(posedge clk) begin
		if (item_fire && item.req_type == REQ_IMU) begin
			if (item.word_index == IDX_FIRST) begin
				imu_w0_q <= item.data_word;
			end
			if (item.word_index == IDX_SECOND) begin
				imu_w1_q <= item.data_word;
			end
		end
		if (item_fire && (item.req_type == REQ_LEFT || item.req_type == REQ_RIGHT) &&
			item.word_index == IDX_FIRST) begin
			press_w0_q <= item.data_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				raw_q[i]      <= '0;
				offset_q[i]   <= '0;
				angle_sm_q[i] <= '0;
			end
			for (int i = 0; i < 8; i++) begin
				pressure_q[i] <= '0;
			end
			req_en_q <= 1'b0;
			fresh_q  <= 1'b0;
			status_q <= STATUS_STAND;
			busy_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (imu_update) begin
				for (int i = 0; i < 3; i++) begin
					raw_q[i]      <= raw_d[i];
					angle_sm_q[i] <= angle_d[i];
				end
			end
			if (press_update) begin
				for (int i = 0; i < 4; i++) begin
					if (item.req_type == REQ_LEFT) begin
						pressure_q[i] <= press_d[i];
					end else begin
						pressure_q[i + 4] <= press_d[i];
					end
				end
			end
			if (ctrl_write) begin
				req_en_q <= item.data_word[CTRL_REQUEST_BIT];
				fresh_q  <= 1'b1;
				if (item.data_word[CTRL_TARE_BIT]) begin
					for (int i = 0; i < 3; i++) begin
						offset_q[i] <= raw_q[i];
					end
				end
			end
			if (start) begin
				status_q <= status_d;
				fresh_q  <= 1'b0;
				busy_q   <= 1'b1;
				cnt_q    <= '0;
			end else begin
				if (frame_done) begin
					busy_q <= 1'b0;
				end
				if (frame_fire) begin
					cnt_q <= cnt_q + 3'd1;
				end
			end
		end
	end

	// Frame byte stream: three angles then eight pressures, high byte first.
	assign flat = {angle_sm_q[0], angle_sm_q[1], angle_sm_q[2],
		1'b0, pressure_q[0], 1'b0, pressure_q[1], 1'b0, pressure_q[2], 1'b0, pressure_q[3],
		1'b0, pressure_q[4], 1'b0, pressure_q[5], 1'b0, pressure_q[6], 1'b0, pressure_q[7]};

	assign frame_valid = busy_q;

	always_comb begin
		frame.word_number = cnt_q;
		frame.last_word   = (cnt_q == FRAME_LAST);
		case (cnt_q)
			3'd0:    frame.packet_word = {FRAME_HEADER, flat[175:168]};
			3'd1:    frame.packet_word = flat[167:136];
			3'd2:    frame.packet_word = {flat[135:128], status_q, FRAME_FILL, flat[127:120]};
			3'd3:    frame.packet_word = flat[119:88];
			3'd4:    frame.packet_word = flat[87:56];
			3'd5:    frame.packet_word = flat[55:24];
			default: frame.packet_word = {flat[23:0], FRAME_TRAILER};
		endcase
	end

endmodule

`default_nettype wire

[hw/rtl/sfp_checker.sv]
`default_nettype none

module sfp_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                item_ready,
	input wire logic                frame_valid,
	input wire logic                frame_ready,
	input wire sfp_pkg::frame_word_t frame
);
	import sfp_pkg::*;

	// Inside a burst each taken beat is followed by the next word of the frame.
	a_word_step: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && frame_ready && !frame.last_word |=>
			frame_valid && frame.word_number == 3'($past(frame.word_number) + 3'd1))
		else $error("frame word number did not advance");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid |-> (frame.last_word == (frame.word_number == FRAME_LAST)))
		else $error("last word flag out of step with word number");

	a_burst_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(frame_valid) |-> frame.word_number == 3'd0)
		else $error("frame burst did not start at word zero");

	// Input is held back while a frame is in flight, up to its final beat.
	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && !(frame_ready && frame.last_word) |-> !item_ready)
		else $error("item taken in the middle of a frame burst");

	a_stall_stable: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && !frame_ready |=> frame_valid && $stable(frame))
		else $error("stalled frame beat changed");

endmodule

bind sensor_frame_packer_top sfp_checker u_sfp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_ready  (item_ready),
	.frame_valid (frame_valid),
	.frame_ready (frame_ready),
	.frame       (frame)
);

`default_nettype wire

[dv/sensor_frame_packer_top_tb.sv]
`timescale 1ns / 1ps

module sensor_frame_packer_top_tb;
	import sfp_pkg::*;

	localparam int unsigned HOLD_OFF_CYCLES = 80;
	localparam int unsigned SETTLE_CYCLES   = 4;
	localparam int unsigned IDLE_LIMIT      = 4000;
	localparam int unsigned RANDOM_ITEMS    = 72;

	typedef struct {
		item_t       beat;
		int unsigned send_idle;
		int unsigned recv_stall;
		bit          wait_drained;
		bit          long_hold;
	} stim_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	item_t       item = '0;
	logic        frame_valid;
	logic        frame_ready = 1'b0;
	frame_word_t frame;

	// Stimulus side.
	stim_t       pending_items [$];
	int unsigned phase_send;
	int unsigned phase_recv;
	bit          mark_drain;
	bit          mark_hold;
	bit          imu_first_set;
	bit          imu_second_set;
	bit          press_first_set;
	int unsigned recv_stall_pct;
	int unsigned hold_requests;
	int unsigned hold_seen;
	int unsigned hold_left;
	int unsigned settle_count;
	int unsigned stalled_cycles;

	// Mirror of the packer state.
	logic [31:0] imu_words [2];
	logic [15:0] raw_angle [3];
	logic [15:0] tare_angle [3];
	logic [15:0] angle_out [3];
	logic [31:0] press_words [2];
	logic [14:0] foot_press [8];
	logic        frame_armed;
	logic        settings_new;
	logic [7:0]  stand_char;
	frame_word_t expected_words [$];
	int unsigned words_outstanding;
	int unsigned mismatches;
	int unsigned items_taken;
	int unsigned words_checked;
	int unsigned frames_seen;

	sensor_frame_packer_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.frame_valid (frame_valid),
		.frame_ready (frame_ready),
		.frame       (frame)
	);

	always #4 clk = ~clk;

	function automatic int sm_to_hundredths(logic [15:0] h);
		return h[15] ? -int'(h[14:0]) : int'(h[14:0]);
	endfunction

	task automatic update_packer(item_t it);
		int          d;
		int          a;
		int          base;
		logic [15:0] half;
		logic [15:0] halves [11];
		logic [7:0]  b [22];
		logic [31:0] w [7];
		frame_word_t fw;
		case (it.req_type)
			REQ_IMU: begin
				if (it.word_index == IDX_FIRST || it.word_index == IDX_SECOND) begin
					imu_words[it.word_index[0]] = it.data_word;
				end else if (it.word_index == IDX_IMU_LAST && imu_words[0] != imu_words[1]) begin
					raw_angle[0] = 16'(sm_to_hundredths(imu_words[0][31:16]));
					raw_angle[1] = 16'(sm_to_hundredths(imu_words[0][15:0]));
					raw_angle[2] = 16'(sm_to_hundredths(imu_words[1][31:16]));
					for (int i = 0; i < 3; i++) begin
						d = int'($signed(raw_angle[i])) - int'($signed(tare_angle[i]));
						if (d < -int'(HALF_TURN))
							d = d + int'(FULL_TURN);
						else if (d > int'(HALF_TURN))
							d = d - int'(FULL_TURN);
						angle_out[i] = 16'(d);
					end
				end
			end
			REQ_LEFT, REQ_RIGHT: begin
				if (it.word_index == IDX_FIRST || it.word_index == IDX_SECOND) begin
					press_words[it.word_index[0]] = it.data_word;
					if (it.word_index == IDX_SECOND) begin
						base = (it.req_type == REQ_LEFT) ? 0 : 4;
						for (int k = 0; k < 4; k++) begin
							half = (k % 2 == 1) ? press_words[k / 2][15:0] : press_words[k / 2][31:16];
							foot_press[base + k] = half[15] ? 15'd0 : half[14:0];
						end
					end
				end
			end
			REQ_SETTINGS: begin
				if (it.word_index == IDX_SECOND) begin
					frame_armed = it.data_word[CTRL_REQUEST_BIT];
					settings_new = 1'b1;
					if (it.data_word[CTRL_TARE_BIT])
						tare_angle = raw_angle;
				end
			end
			REQ_PACKET: begin
				if (frame_armed && settings_new) begin
					// A fall with an unknown side leaves the previous status in place.
					if (!it.stop_walk)
						stand_char = STATUS_STAND;
					else if (it.fall_side == SIDE_FORWARD)
						stand_char = STATUS_FORWARD;
					else if (it.fall_side == SIDE_BACKWARD)
						stand_char = STATUS_BACKWARD;
					for (int i = 0; i < 3; i++) begin
						a = int'($signed(angle_out[i]));
						halves[i] = (a < 0) ? {1'b1, 15'(-a)} : angle_out[i];
					end
					for (int i = 0; i < 8; i++)
						halves[i + 3] = {1'b0, foot_press[i]};
					for (int i = 0; i < 11; i++) begin
						b[2 * i] = halves[i][15:8];
						b[2 * i + 1] = halves[i][7:0];
					end
					w[0] = {FRAME_HEADER, b[0]};
					w[1] = {b[1], b[2], b[3], b[4]};
					w[2] = {b[5], stand_char, FRAME_FILL, b[6]};
					w[3] = {b[7], b[8], b[9], b[10]};
					w[4] = {b[11], b[12], b[13], b[14]};
					w[5] = {b[15], b[16], b[17], b[18]};
					w[6] = {b[19], b[20], b[21], FRAME_TRAILER};
					for (int i = 0; i < 7; i++) begin
						fw.packet_word = w[i];
						fw.word_number = 3'(i);
						fw.last_word = (3'(i) == FRAME_LAST);
						expected_words.push_back(fw);
					end
					settings_new = 1'b0;
				end
			end
			default: begin
			end
		endcase
	endtask

	// Items that would read a hold word never written are dropped here.
	task automatic queue_item(logic [2:0] kind, logic [31:0] word, logic [2:0] idx,
			logic stop, logic [1:0] side);
		stim_t s;
		if (kind == REQ_IMU && idx == IDX_IMU_LAST && !(imu_first_set && imu_second_set))
			return;
		if ((kind == REQ_LEFT || kind == REQ_RIGHT) && idx == IDX_SECOND && !press_first_set)
			return;
		if (kind == REQ_IMU && idx == IDX_FIRST)
			imu_first_set = 1'b1;
		if (kind == REQ_IMU && idx == IDX_SECOND)
			imu_second_set = 1'b1;
		if ((kind == REQ_LEFT || kind == REQ_RIGHT) && idx == IDX_FIRST)
			press_first_set = 1'b1;
		s.beat.req_type = kind;
		s.beat.data_word = word;
		s.beat.word_index = idx;
		s.beat.stop_walk = stop;
		s.beat.fall_side = side;
		s.send_idle = phase_send;
		s.recv_stall = phase_recv;
		s.wait_drained = mark_drain;
		s.long_hold = mark_hold;
		mark_drain = 1'b0;
		mark_hold = 1'b0;
		pending_items.push_back(s);
	endtask

	task automatic queue_imu(logic [31:0] w0, logic [31:0] w1);
		queue_item(REQ_IMU, w0, IDX_FIRST, 1'($urandom_range(1)), 2'($urandom_range(3)));
		queue_item(REQ_IMU, w1, IDX_SECOND, 1'($urandom_range(1)), 2'($urandom_range(3)));
		queue_item(REQ_IMU, $urandom,
			3'($urandom_range(int'(IDX_IMU_LAST) - 1, int'(IDX_SECOND) + 1)),
			1'($urandom_range(1)), 2'($urandom_range(3)));
		queue_item(REQ_IMU, $urandom, IDX_IMU_LAST, 1'($urandom_range(1)),
			2'($urandom_range(3)));
	endtask

	task automatic queue_press(logic [2:0] kind, logic [31:0] w0, logic [31:0] w1);
		queue_item(kind, w0, IDX_FIRST, 1'($urandom_range(1)), 2'($urandom_range(3)));
		queue_item(kind, w1, IDX_SECOND, 1'($urandom_range(1)), 2'($urandom_range(3)));
	endtask

	task automatic queue_settings(logic request, logic tare);
		logic [31:0] w;
		w = $urandom;
		w[CTRL_REQUEST_BIT] = request;
		w[CTRL_TARE_BIT] = tare;
		queue_item(REQ_SETTINGS, w, IDX_SECOND, 1'($urandom_range(1)), 2'($urandom_range(3)));
	endtask

	task automatic queue_packet(logic stop, logic [1:0] side);
		queue_item(REQ_PACKET, $urandom, 3'($urandom_range(7)), stop, side);
	endtask

	// Angle halves are biased toward the wrap limits and the ends of the range.
	function automatic logic [15:0] rand_angle_half();
		logic [14:0] mag;
		case ($urandom_range(3))
			0: mag = 15'($urandom_range(32767));
			1: mag = 15'(int'(HALF_TURN) - 2 + $urandom_range(4));
			2: mag = 15'($urandom_range(300));
			default: mag = $urandom_range(1) ? 15'h7FFF : 15'h0000;
		endcase
		return {1'($urandom_range(1)), mag};
	endfunction

	// Driver: one item per accepted beat; valid holds until the block takes it.
	always @(posedge clk or negedge arst_n) begin
		stim_t head;
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
			recv_stall_pct <= 0;
			hold_requests <= 0;
			settle_count = 0;
		end else if (!item_valid || item_ready) begin
			if (pending_items.size() == 0) begin
				item_valid <= 1'b0;
			end else if (pending_items[0].wait_drained &&
					(words_outstanding != 0 || settle_count < SETTLE_CYCLES)) begin
				item_valid <= 1'b0;
				settle_count = (words_outstanding != 0) ? 0 : settle_count + 1;
			end else if ($urandom_range(99) < pending_items[0].send_idle) begin
				item_valid <= 1'b0;
			end else begin
				head = pending_items.pop_front();
				item_valid <= 1'b1;
				item <= head.beat;
				recv_stall_pct <= head.recv_stall;
				if (head.long_hold)
					hold_requests <= hold_requests + 1;
				settle_count = 0;
			end
		end
	end

	// Frame receiver, with an occasional long hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_ready <= 1'b0;
			hold_left = 0;
			hold_seen = 0;
		end else if (hold_left != 0) begin
			hold_left = hold_left - 1;
			frame_ready <= 1'b0;
		end else if (hold_seen != hold_requests) begin
			hold_seen = hold_requests;
			hold_left = HOLD_OFF_CYCLES;
			frame_ready <= 1'b0;
		end else begin
			frame_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Monitor: predicts on every accepted item and checks every frame beat.
	always @(posedge clk or negedge arst_n) begin
		frame_word_t want;
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				imu_words[i] = '0;
				press_words[i] = '0;
			end
			for (int i = 0; i < 3; i++) begin
				raw_angle[i] = '0;
				tare_angle[i] = '0;
				angle_out[i] = '0;
			end
			for (int i = 0; i < 8; i++)
				foot_press[i] = '0;
			frame_armed = 1'b0;
			settings_new = 1'b0;
			stand_char = STATUS_STAND;
			expected_words.delete();
			words_outstanding <= 0;
		end else begin
			if (item_valid && item_ready) begin
				update_packer(item);
				items_taken = items_taken + 1;
			end
			if (frame_valid && frame_ready) begin
				if (expected_words.size() == 0) begin
					mismatches = mismatches + 1;
					$display("%0t: unexpected frame beat, expected none, got %h/%0d/%0b",
						$time, frame.packet_word, frame.word_number, frame.last_word);
				end else begin
					want = expected_words.pop_front();
					words_checked = words_checked + 1;
					if (frame.last_word)
						frames_seen = frames_seen + 1;
					if (frame.packet_word !== want.packet_word) begin
						mismatches = mismatches + 1;
						$display("%0t: packet_word expected %h, got %h",
							$time, want.packet_word, frame.packet_word);
					end
					if (frame.word_number !== want.word_number) begin
						mismatches = mismatches + 1;
						$display("%0t: word_number expected %0d, got %0d",
							$time, want.word_number, frame.word_number);
					end
					if (frame.last_word !== want.last_word) begin
						mismatches = mismatches + 1;
						$display("%0t: last_word expected %0b, got %0b",
							$time, want.last_word, frame.last_word);
					end
				end
			end
			words_outstanding <= expected_words.size();
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && item_ready) || (frame_valid && frame_ready)) begin
			stalled_cycles <= 0;
		end else if (stalled_cycles >= IDLE_LIMIT) begin
			$display("%0t: no beat for %0d cycles, %0d frame words outstanding",
				$time, stalled_cycles, expected_words.size());
			$display("sensor_frame_packer_top regression: fail");
			$finish;
		end else begin
			stalled_cycles <= stalled_cycles + 1;
		end
	end

	initial begin
		int unsigned send_mix [4];
		int unsigned recv_mix [4];
		int unsigned phase_items;
		send_mix = '{0, 54, 0, 8};
		recv_mix = '{0, 0, 54, 8};
		mismatches = 0;
		items_taken = 0;
		words_checked = 0;
		frames_seen = 0;
		stalled_cycles = 0;
		phase_send = 0;
		phase_recv = 0;
		mark_drain = 1'b0;
		mark_hold = 1'b0;
		imu_first_set = 1'b0;
		imu_second_set = 1'b0;
		press_first_set = 1'b0;

		// Directed part. A request straight after reset is not armed.
		queue_packet(1'b1, SIDE_FORWARD);
		queue_settings(1'b1, 1'b0);
		// Full-scale roll, full-scale negative pitch, negative zero yaw.
		queue_imu({16'h7FFF, 16'hFFFF}, {16'h8000, 16'h0001});
		queue_press(REQ_LEFT, 32'h8000_7FFF, 32'hFFFF_0000);
		queue_press(REQ_RIGHT, 32'h7FFF_8001, 32'h0000_FFFF);
		queue_packet(1'b1, SIDE_FORWARD);
		// Settings already used by the last frame, so nothing comes out.
		queue_packet(1'b0, SIDE_FORWARD);
		queue_settings(1'b1, 1'b1);
		queue_imu(32'h1234_5678, 32'h1234_5678);
		// After the tare these wrap past both limits; yaw lands exactly on the limit.
		queue_imu({16'hFFFF, 16'h7FFF}, {16'h4650, 16'hA5A5});
		queue_settings(1'b1, 1'b0);
		queue_packet(1'b1, SIDE_BACKWARD);
		queue_settings(1'b1, 1'b0);
		queue_packet(1'b1, 2'($urandom_range(3, 2)));
		queue_settings(1'b0, 1'b0);
		queue_packet(1'b0, SIDE_FORWARD);
		queue_item(3'($urandom_range(7, int'(REQ_PACKET) + 1)), $urandom, IDX_SECOND,
			1'b1, SIDE_BACKWARD);
		queue_item(REQ_IMU, $urandom, 3'($urandom_range(7, int'(IDX_IMU_LAST) + 1)),
			1'b0, SIDE_FORWARD);

		for (int p = 0; p < 4; p++) begin
			phase_send = send_mix[p];
			phase_recv = recv_mix[p];
			mark_drain = 1'b1;
			if (p == 0) begin
				// The receiver holds off while several frames are requested back to back.
				mark_hold = 1'b1;
				for (int i = 0; i < 3; i++) begin
					queue_settings(1'b1, 1'($urandom_range(1)));
					queue_packet(1'($urandom_range(1)), 2'($urandom_range(3)));
				end
			end
			phase_items = 0;
			while (phase_items < RANDOM_ITEMS / 4) begin
				case ($urandom_range(9))
					0, 1, 2: begin
						queue_settings(1'($urandom_range(9) != 0), 1'($urandom_range(3) == 0));
						queue_packet(1'($urandom_range(1)), 2'($urandom_range(3)));
						phase_items = phase_items + 2;
					end
					3, 4: begin
						if ($urandom_range(5) == 0)
							queue_imu({rand_angle_half(), rand_angle_half()},
								{rand_angle_half(), rand_angle_half()});
						else
							queue_imu({rand_angle_half(), rand_angle_half()},
								{rand_angle_half(), 16'($urandom)});
						phase_items = phase_items + 4;
					end
					5, 6: begin
						queue_press($urandom_range(1) ? REQ_LEFT : REQ_RIGHT, $urandom, $urandom);
						phase_items = phase_items + 2;
					end
					7: begin
						// A request with no fresh settings in front of it.
						queue_packet(1'($urandom_range(1)), 2'($urandom_range(3)));
						phase_items = phase_items + 1;
					end
					default: begin
						queue_item(3'($urandom_range(7)), $urandom, 3'($urandom_range(7)),
							1'($urandom_range(1)), 2'($urandom_range(3)));
						phase_items = phase_items + 1;
					end
				endcase
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(negedge clk);
		while (pending_items.size() != 0 || item_valid || expected_words.size() != 0);
		repeat (4 * SETTLE_CYCLES) @(negedge clk);

		$display("Drove %0d items: directed corners, then random groups under four idle mixes",
			items_taken);
		$display("and one long frame hold-off; %0d frame beats in %0d frames checked.",
			words_checked, frames_seen);
		if (expected_words.size() != 0)
			$display("%0t: %0d expected frame beats never arrived",
				$time, expected_words.size());
		if (mismatches == 0 && expected_words.size() == 0) begin
			$display("sensor_frame_packer_top regression: pass");
		end else begin
			$display("sensor_frame_packer_top regression: fail");
		end
		$finish;
	end

endmodule
